>>> hdl/gdbd_pkg.sv
package gdbd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DAYS_W  = 22;

  // latest year accepted as a real date
  localparam int unsigned MAX_YEAR = 9999;

  // day count from year 0, one bit of headroom over the result so that
  // years above the limit (flagged invalid) do not wrap inside the stages
  localparam int unsigned CNT_W = DAYS_W + 1;

  // day offset within a year: days before the month, plus day, plus leap day
  localparam int unsigned OFF_W = 9;
  localparam int unsigned MLEN_W = 5;

  // floor(x / 100) as (x * RECIP_100) >> RECIP_SHIFT, exact for x below 43000
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned PROD_W      = 28;
  localparam int unsigned Q100_W      = 8;
  localparam int unsigned Q400_W      = 6;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned CENTURY       = 100;

  // register stages from input to output beat
  localparam int unsigned NUM_STAGES = 4;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [MLEN_W-1:0] FEB_LEAP_LEN = MLEN_W'(29);

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_adv_t;

  // days of a common year before the first of the month
  function automatic logic [OFF_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [OFF_W-1:0] r;
    case (m)
      4'd1:    r = OFF_W'(0);
      4'd2:    r = OFF_W'(31);
      4'd3:    r = OFF_W'(59);
      4'd4:    r = OFF_W'(90);
      4'd5:    r = OFF_W'(120);
      4'd6:    r = OFF_W'(151);
      4'd7:    r = OFF_W'(181);
      4'd8:    r = OFF_W'(212);
      4'd9:    r = OFF_W'(243);
      4'd10:   r = OFF_W'(273);
      4'd11:   r = OFF_W'(304);
      4'd12:   r = OFF_W'(334);
      default: r = '0;
    endcase
    return r;
  endfunction

  // month length in a common year
  function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [MLEN_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = MLEN_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    r = MLEN_W'(30);
      4'd2:                                       r = MLEN_W'(28);
      default:                                    r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/gdbd_ctrl.sv
module gdbd_ctrl
  import gdbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output pipe_adv_t adv_o
);

  logic [NUM_STAGES-1:0] valid_d, valid_q;
  logic [NUM_STAGES-1:0] ready;

  always_comb begin
    ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d        = valid_q;
    adv_o.load     = '0;
    valid_d[0]     = ready[0] ? in_valid_i : valid_q[0];
    adv_o.load[0]  = ready[0] && in_valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k]    = ready[k] ? valid_q[k-1] : valid_q[k];
      adv_o.load[k] = ready[k] && valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  // a full pipe held at the output must push back at the input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q && out_stall_i) |-> in_stall_o)
    else $error("full pipe did not stall input");

  // an empty output stage leaves room everywhere
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[NUM_STAGES-1] |-> !in_stall_o)
    else $error("input stalled with free output stage");

  // input back pressure only originates at the output
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

endmodule

>>> hdl/gdbd_date_conv.sv
module gdbd_date_conv
  import gdbd_pkg::*;
(
  input  logic               clk_i,
  input  pipe_adv_t          adv_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DAY_W-1:0]   day_i,
  output logic               date_ok_o,
  output logic [CNT_W-1:0]   count_o
);

  // stage 1: century quotients, month table
  logic [PROD_W-1:0]  p_q100, p_c100, p_c400;
  logic [YEAR_W:0]    y_p99, y_p399;
  logic [YEAR_W-1:0]  s1_year_q;
  logic [MONTH_W-1:0] s1_month_q;
  logic [DAY_W-1:0]   s1_day_q;
  logic [Q100_W-1:0]  s1_q100_q, s1_c100_q;
  logic [Q400_W-1:0]  s1_c400_q;
  logic [OFF_W-1:0]   s1_dbm_q;
  logic [MLEN_W-1:0]  s1_len_q;
  logic               s1_mok_q;

  always_comb begin
    y_p99  = {1'b0, year_i} + (YEAR_W+1)'(CENTURY - 1);
    y_p399 = {1'b0, year_i} + (YEAR_W+1)'(4 * CENTURY - 1);
    p_q100 = PROD_W'(year_i) * PROD_W'(RECIP_100);
    p_c100 = PROD_W'(y_p99) * PROD_W'(RECIP_100);
    p_c400 = PROD_W'(y_p399[YEAR_W:2]) * PROD_W'(RECIP_100);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.load[0]) begin
      s1_year_q  <= year_i;
      s1_month_q <= month_i;
      s1_day_q   <= day_i;
      s1_q100_q  <= Q100_W'(p_q100 >> RECIP_SHIFT);
      s1_c100_q  <= Q100_W'(p_c100 >> RECIP_SHIFT);
      s1_c400_q  <= Q400_W'(p_c400 >> RECIP_SHIFT);
      s1_dbm_q   <= days_before(month_i);
      s1_len_q   <= month_len(month_i);
      s1_mok_q   <= (month_i >= MONTH_JAN) && (month_i <= MONTH_DEC);
    end
  end

  // stage 2: leap rule, validity, year base count, offset within year
  logic               leap, year_ok, day_ok;
  logic [MLEN_W-1:0]  len_eff;
  logic [YEAR_W:0]    cent_prod;
  logic [YEAR_W:0]    y_p3;
  logic [CNT_W-1:0]   base_d;
  logic [OFF_W-1:0]   off_d;
  logic               s2_ok_q;
  logic [CNT_W-1:0]   s2_base_q;
  logic [OFF_W-1:0]   s2_off_q;

  always_comb begin
    cent_prod = (YEAR_W+1)'(s1_q100_q) * (YEAR_W+1)'(CENTURY);
    leap      = (s1_year_q[1:0] == 2'b00)
             && ((cent_prod != {1'b0, s1_year_q}) || (s1_q100_q[1:0] == 2'b00));
    year_ok   = 32'(s1_year_q) <= MAX_YEAR;
    len_eff   = (s1_month_q == MONTH_FEB && leap) ? FEB_LEAP_LEN : s1_len_q;
    day_ok    = (s1_day_q != '0) && (MLEN_W'(s1_day_q) <= len_eff);
    y_p3      = {1'b0, s1_year_q} + (YEAR_W+1)'(3);
    base_d    = CNT_W'(s1_year_q) * CNT_W'(DAYS_PER_YEAR)
              + CNT_W'(y_p3[YEAR_W:2]) + CNT_W'(s1_c400_q) - CNT_W'(s1_c100_q);
    off_d     = s1_dbm_q + OFF_W'(s1_day_q)
              + OFF_W'((s1_month_q > MONTH_FEB) && leap);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.load[1]) begin
      s2_ok_q   <= year_ok && s1_mok_q && day_ok;
      s2_base_q <= base_d;
      s2_off_q  <= off_d;
    end
  end

  // stage 3: final day count
  logic             s3_ok_q;
  logic [CNT_W-1:0] s3_count_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.load[2]) begin
      s3_ok_q    <= s2_ok_q;
      s3_count_q <= s2_base_q + CNT_W'(s2_off_q);
    end
  end

  assign date_ok_o = s3_ok_q;
  assign count_o   = s3_count_q;

endmodule

>>> hdl/gregorian_days_between_dates.sv
// Days between two Gregorian dates. Each input beat carries two dates (year,
// month, day); each output beat reports whether each date is a real calendar
// date and the absolute number of days between them, forced to zero when
// either date is invalid. Years run from 0 (a leap year) to 9999; a later year
// marks the date invalid. The pipe takes one beat per clock while in_stall_o is
// low, and passes each result through three stages per date (century
// quotients and month table, leap rule and year base count, final day count)
// and one stage that forms the absolute difference and holds the output beat.
// Back pressure from out_stall_i reaches in_stall_o only through full stages,
// so bubbles are squeezed out and a held output never loses or repeats a beat.
module gregorian_days_between_dates
  import gdbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [YEAR_W-1:0]  first_year_i,
  input  logic [MONTH_W-1:0] first_month_i,
  input  logic [DAY_W-1:0]   first_day_i,
  input  logic [YEAR_W-1:0]  second_year_i,
  input  logic [MONTH_W-1:0] second_month_i,
  input  logic [DAY_W-1:0]   second_day_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               first_valid_o,
  output logic               second_valid_o,
  output logic [DAYS_W-1:0]  days_apart_o
);

  pipe_adv_t        adv;
  logic             ok_a, ok_b;
  logic [CNT_W-1:0] cnt_a, cnt_b;

  // valid bits and per-stage load enables
  gdbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .adv_o       (adv)
  );

  // one converter per date, both in lockstep
  gdbd_date_conv u_conv_a (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .year_i    (first_year_i),
    .month_i   (first_month_i),
    .day_i     (first_day_i),
    .date_ok_o (ok_a),
    .count_o   (cnt_a)
  );

  gdbd_date_conv u_conv_b (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .year_i    (second_year_i),
    .month_i   (second_month_i),
    .day_i     (second_day_i),
    .date_ok_o (ok_b),
    .count_o   (cnt_b)
  );

  // last stage: absolute difference, masked to the result width
  logic [CNT_W-1:0]  diff;
  logic [DAYS_W-1:0] days_d;
  logic              first_valid_q, second_valid_q;
  logic [DAYS_W-1:0] days_q;

  always_comb begin
    diff   = (cnt_a >= cnt_b) ? (cnt_a - cnt_b) : (cnt_b - cnt_a);
    days_d = (ok_a && ok_b) ? diff[DAYS_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv.load[NUM_STAGES-1]) begin
      first_valid_q  <= ok_a;
      second_valid_q <= ok_b;
      days_q         <= days_d;
    end
  end

  assign first_valid_o  = first_valid_q;
  assign second_valid_o = second_valid_q;
  assign days_apart_o   = days_q;

  // an invalid date never yields a nonzero distance
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !(first_valid_o && second_valid_o)) |-> (days_apart_o == '0))
    else $error("nonzero distance reported for invalid date");

endmodule
